// ===== hdl/g2j_pkg.sv =====
// shared types, constants and tables for the gregorian to jalali converter
package g2j_pkg;

    // number of register stages from input to output
    localparam int NUM_STAGES = 10;

    // configuration register codes
    localparam logic CFG_MIN_YEAR = 1'b0;
    localparam logic CFG_MAX_YEAR = 1'b1;

    localparam logic [13:0] MIN_YEAR_RST = 14'd1970;
    localparam logic [13:0] MAX_YEAR_RST = 14'd2030;

    localparam logic [15:0] EPOCH_YEAR    = 16'd1600;
    localparam logic [22:0] JAL_OFFSET    = 23'd79;
    localparam logic [13:0] JAL_BASE_YEAR = 14'd979;
    localparam int          DAYS_33Y      = 12053;
    localparam int          DAYS_4Y       = 1461;
    localparam int          DAYS_YEAR     = 365;
    localparam int          DAYS_CENTURY  = 100;

    // reciprocal multipliers for the constant divisions
    localparam int          DIV100_SHIFT = 20;
    localparam logic [14:0] DIV100_MULT  =
        15'(((64'd1 << DIV100_SHIFT) + 64'(DAYS_CENTURY) - 64'd1) / 64'(DAYS_CENTURY));
    localparam int          DIV33Y_SHIFT = 37;
    localparam logic [23:0] DIV33Y_MULT  =
        24'(((64'd1 << DIV33Y_SHIFT) + 64'(DAYS_33Y) - 64'd1) / 64'(DAYS_33Y));
    localparam int          DIV4Y_SHIFT  = 25;
    localparam logic [14:0] DIV4Y_MULT   =
        15'(((64'd1 << DIV4Y_SHIFT) + 64'(DAYS_4Y) - 64'd1) / 64'(DAYS_4Y));

    typedef struct packed {
        logic [15:0] greg_year;
        logic [7:0]  greg_month;
        logic [7:0]  greg_day;
    } g2j_in_t;

    typedef struct packed {
        logic        valid_res;
        logic [13:0] jal_year;
        logic [3:0]  jal_month;
        logic [4:0]  jal_day;
    } g2j_out_t;

    // day number since the jalali new year of the count
    typedef struct packed {
        logic        ok;
        logic [22:0] jdn;
    } g2j_days_t;

    // jalali year and zero based day of year
    typedef struct packed {
        logic        ok;
        logic [13:0] jy;
        logic [8:0]  doy;
    } g2j_yday_t;

    // days in a common gregorian year before the first of the month
    function automatic logic [8:0] greg_cum(input logic [3:0] month);
        logic [8:0] r;
        unique case (month)
            4'd2:    r = 9'd31;
            4'd3:    r = 9'd59;
            4'd4:    r = 9'd90;
            4'd5:    r = 9'd120;
            4'd6:    r = 9'd151;
            4'd7:    r = 9'd181;
            4'd8:    r = 9'd212;
            4'd9:    r = 9'd243;
            4'd10:   r = 9'd273;
            4'd11:   r = 9'd304;
            4'd12:   r = 9'd334;
            default: r = 9'd0;
        endcase
        return r;
    endfunction

    // days of the jalali year before month index idx (zero based)
    function automatic logic [8:0] jal_cum(input logic [3:0] idx);
        logic [8:0] r;
        unique case (idx)
            4'd1:    r = 9'd31;
            4'd2:    r = 9'd62;
            4'd3:    r = 9'd93;
            4'd4:    r = 9'd124;
            4'd5:    r = 9'd155;
            4'd6:    r = 9'd186;
            4'd7:    r = 9'd216;
            4'd8:    r = 9'd246;
            4'd9:    r = 9'd276;
            4'd10:   r = 9'd306;
            4'd11:   r = 9'd336;
            default: r = 9'd0;
        endcase
        return r;
    endfunction

endpackage

// ===== hdl/g2j_pipe_ctrl.sv =====
// valid bits and per-stage load enables of the conversion pipeline
module g2j_pipe_ctrl
    import g2j_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_stall,
    output logic                  out_valid,
    input  logic                  out_stall,
    output logic [NUM_STAGES-1:0] ld
);

    logic [NUM_STAGES-1:0] v_reg;
    logic [NUM_STAGES-1:0] v_next;

    // a stage loads when it is empty or its content moves on
    always_comb
    begin
        ld[NUM_STAGES-1] = !v_reg[NUM_STAGES-1] || !out_stall;
        for (int k = NUM_STAGES - 2; k >= 0; k--)
        begin
            ld[k] = !v_reg[k] || ld[k+1];
        end
        v_next[0] = ld[0] ? in_valid : v_reg[0];
        for (int k = 1; k < NUM_STAGES; k++)
        begin
            v_next[k] = ld[k] ? v_reg[k-1] : v_reg[k];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else
        begin
            v_reg <= v_next;
        end
    end

    assign in_stall  = !ld[0];
    assign out_valid = v_reg[NUM_STAGES-1];

endmodule

// ===== hdl/g2j_day_count.sv =====
// input checks and day count since the jalali new year, stages 0 to 3
module g2j_day_count
    import g2j_pkg::*;
(
    input  logic        clk,
    input  logic [3:0]  ld,
    input  g2j_in_t     in_data,
    input  logic [13:0] min_year,
    input  logic [13:0] max_year,
    output g2j_days_t   days
);

    // stage 0: range checks and table lookup
    logic        s0_ok_next, s0_ok_reg;
    logic [13:0] s0_gy_next, s0_gy_reg;
    logic [8:0]  s0_cum_next, s0_cum_reg;
    logic        s0_mgt2_next, s0_mgt2_reg;
    logic [4:0]  s0_dm1_next, s0_dm1_reg;

    always_comb
    begin
        s0_ok_next = (in_data.greg_year >= {2'b00, min_year})
                  && (in_data.greg_year <= {2'b00, max_year})
                  && (in_data.greg_year >= EPOCH_YEAR)
                  && (in_data.greg_month >= 8'd1) && (in_data.greg_month <= 8'd12)
                  && (in_data.greg_day >= 8'd1) && (in_data.greg_day <= 8'd31);
        s0_gy_next   = 14'(in_data.greg_year - EPOCH_YEAR);
        s0_cum_next  = greg_cum(in_data.greg_month[3:0]);
        s0_mgt2_next = in_data.greg_month > 8'd2;
        s0_dm1_next  = 5'(in_data.greg_day[4:0] - 5'd1);
    end

    // stage 1: years since epoch divided by one hundred
    logic [28:0] s1_prod;
    logic [7:0]  s1_f100_next, s1_f100_reg;
    logic        s1_ok_reg;
    logic [13:0] s1_gy_reg;
    logic [8:0]  s1_cum_reg;
    logic        s1_mgt2_reg;
    logic [4:0]  s1_dm1_reg;

    always_comb
    begin
        s1_prod      = 29'(s0_gy_reg) * 29'(DIV100_MULT);
        s1_f100_next = s1_prod[DIV100_SHIFT +: 8];
    end

    // stage 2: leap corrections and whole-year days
    logic [13:0] s2_rfull;
    logic        s2_rnz;
    logic        s2_leap;
    logic [7:0]  s2_c100;
    logic [8:0]  s2_c100p3;
    logic [14:0] s2_gyp3;
    logic [12:0] s2_corr;
    logic [12:0] s2_small_next, s2_small_reg;
    logic [22:0] s2_base_next, s2_base_reg;
    logic        s2_ok_reg;

    always_comb
    begin
        s2_rfull  = s1_gy_reg - 14'(s1_f100_reg * 14'd100);
        s2_rnz    = s2_rfull[6:0] != 7'd0;
        s2_leap   = ((s1_gy_reg[1:0] == 2'b00) && s2_rnz)
                 || (!s2_rnz && (s1_f100_reg[1:0] == 2'b00));
        s2_c100   = s1_f100_reg + 8'(s2_rnz);
        s2_c100p3 = {1'b0, s2_c100} + 9'd3;
        s2_gyp3   = {1'b0, s1_gy_reg} + 15'd3;
        s2_corr   = s2_gyp3[14:2] - 13'(s2_c100) + 13'(s2_c100p3[8:2]);
        s2_small_next = s2_corr + 13'(s1_cum_reg) + 13'(s2_leap && s1_mgt2_reg)
                      + 13'(s1_dm1_reg);
        s2_base_next  = 23'(s1_gy_reg) * 23'(DAYS_YEAR);
    end

    // stage 3: total day count less the offset
    logic [22:0] s3_gdn;
    g2j_days_t   s3_next, s3_reg;

    always_comb
    begin
        s3_gdn      = s2_base_reg + 23'(s2_small_reg);
        s3_next.ok  = s2_ok_reg && (s3_gdn >= JAL_OFFSET);
        s3_next.jdn = s3_gdn - JAL_OFFSET;
    end

    always_ff @(posedge clk)
    begin
        if (ld[0])
        begin
            s0_ok_reg   <= s0_ok_next;
            s0_gy_reg   <= s0_gy_next;
            s0_cum_reg  <= s0_cum_next;
            s0_mgt2_reg <= s0_mgt2_next;
            s0_dm1_reg  <= s0_dm1_next;
        end
        if (ld[1])
        begin
            s1_f100_reg <= s1_f100_next;
            s1_ok_reg   <= s0_ok_reg;
            s1_gy_reg   <= s0_gy_reg;
            s1_cum_reg  <= s0_cum_reg;
            s1_mgt2_reg <= s0_mgt2_reg;
            s1_dm1_reg  <= s0_dm1_reg;
        end
        if (ld[2])
        begin
            s2_small_reg <= s2_small_next;
            s2_base_reg  <= s2_base_next;
            s2_ok_reg    <= s1_ok_reg;
        end
        if (ld[3])
        begin
            s3_reg <= s3_next;
        end
    end

    assign days = s3_reg;

endmodule

// ===== hdl/g2j_cycle_split.sv =====
// split of the day count by 33-year, 4-year and 1-year cycles, stages 4 to 8
module g2j_cycle_split
    import g2j_pkg::*;
(
    input  logic       clk,
    input  logic [4:0] ld,
    input  g2j_days_t  days,
    output g2j_yday_t  yday
);

    // stage 4: number of whole 33-year cycles
    logic [47:0] s4_prod;
    logic [8:0]  s4_q_next, s4_q_reg;
    g2j_days_t   s4_days_reg;

    always_comb
    begin
        s4_prod   = 48'(days.jdn) * 48'(DIV33Y_MULT);
        s4_q_next = s4_prod[DIV33Y_SHIFT +: 9];
    end

    // stage 5: remainder within the cycle and year so far
    logic [22:0] s5_mul;
    logic [13:0] s5_rem_next, s5_rem_reg;
    logic [13:0] s5_jy_next, s5_jy_reg;
    logic        s5_ok_reg;

    always_comb
    begin
        s5_mul      = 23'(s4_q_reg) * 23'(DAYS_33Y);
        s5_rem_next = 14'(s4_days_reg.jdn - s5_mul);
        s5_jy_next  = JAL_BASE_YEAR + 14'(14'(s4_q_reg) * 14'd33);
    end

    // stage 6: number of whole 4-year cycles
    logic [28:0] s6_prod;
    logic [3:0]  s6_q_next, s6_q_reg;
    logic [13:0] s6_rem_reg;
    logic [13:0] s6_jy_reg;
    logic        s6_ok_reg;

    always_comb
    begin
        s6_prod   = 29'(s5_rem_reg) * 29'(DIV4Y_MULT);
        s6_q_next = s6_prod[DIV4Y_SHIFT +: 4];
    end

    // stage 7: remainder within the 4-year cycle
    logic [10:0] s7_rem_next, s7_rem_reg;
    logic [13:0] s7_jy_next, s7_jy_reg;
    logic        s7_ok_reg;

    always_comb
    begin
        s7_rem_next = 11'(s6_rem_reg - 14'(14'(s6_q_reg) * 14'(DAYS_4Y)));
        s7_jy_next  = s6_jy_reg + {8'd0, s6_q_reg, 2'b00};
    end

    // stage 8: single years, the first of each group being the long one
    logic [10:0] s8_t;
    logic [1:0]  s8_qy;
    logic [10:0] s8_sub;
    g2j_yday_t   s8_next, s8_reg;

    always_comb
    begin
        s8_t = s7_rem_reg - 11'd1;
        priority if (s7_rem_reg < 11'd366)
        begin
            s8_qy  = 2'd0;
            s8_sub = 11'd0;
            s8_t   = s7_rem_reg;
        end
        else if (s8_t >= 11'd1095)
        begin
            s8_qy  = 2'd3;
            s8_sub = 11'd1095;
        end
        else if (s8_t >= 11'd730)
        begin
            s8_qy  = 2'd2;
            s8_sub = 11'd730;
        end
        else if (s8_t >= 11'd365)
        begin
            s8_qy  = 2'd1;
            s8_sub = 11'd365;
        end
        else
        begin
            s8_qy  = 2'd0;
            s8_sub = 11'd0;
        end
        s8_next.ok  = s7_ok_reg;
        s8_next.jy  = s7_jy_reg + 14'(s8_qy);
        s8_next.doy = 9'(s8_t - s8_sub);
    end

    always_ff @(posedge clk)
    begin
        if (ld[0])
        begin
            s4_q_reg    <= s4_q_next;
            s4_days_reg <= days;
        end
        if (ld[1])
        begin
            s5_rem_reg <= s5_rem_next;
            s5_jy_reg  <= s5_jy_next;
            s5_ok_reg  <= s4_days_reg.ok;
        end
        if (ld[2])
        begin
            s6_q_reg   <= s6_q_next;
            s6_rem_reg <= s5_rem_reg;
            s6_jy_reg  <= s5_jy_reg;
            s6_ok_reg  <= s5_ok_reg;
        end
        if (ld[3])
        begin
            s7_rem_reg <= s7_rem_next;
            s7_jy_reg  <= s7_jy_next;
            s7_ok_reg  <= s6_ok_reg;
        end
        if (ld[4])
        begin
            s8_reg <= s8_next;
        end
    end

    assign yday = s8_reg;

endmodule

// ===== hdl/g2j_month_walk.sv =====
// month and day from the day of year, output register, stage 9
module g2j_month_walk
    import g2j_pkg::*;
(
    input  logic      clk,
    input  logic      ld,
    input  g2j_yday_t yday,
    output g2j_out_t  out_data
);

    logic [3:0] idx;
    logic [8:0] dd;
    g2j_out_t   res_next, res_reg;

    always_comb
    begin
        idx = 4'd0;
        // thresholds rise, so the last one passed is the month index
        for (int k = 1; k < 12; k++)
        begin
            if (yday.doy >= jal_cum(4'(k)))
            begin
                idx = 4'(k);
            end
        end
        dd = yday.doy - jal_cum(idx);
        if (yday.ok)
        begin
            res_next.valid_res = 1'b1;
            res_next.jal_year  = yday.jy;
            res_next.jal_month = idx + 4'd1;
            res_next.jal_day   = dd[4:0] + 5'd1;
        end
        else
        begin
            res_next = '0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ld)
        begin
            res_reg <= res_next;
        end
    end

    assign out_data = res_reg;

endmodule

// ===== hdl/gregorian_to_jalali_core.sv =====
// top level of the gregorian to jalali date converter
//
// usage
//   input channel: in_valid / in_stall / in_data (gregorian year, month, day);
//   a transaction happens on a rising edge with in_valid high and in_stall low
//   output channel: out_valid / out_stall / out_data, one result per input
//   transaction, in order; invalid dates come out with every field zero
//   configuration: cfg_wr_en writes cfg_data into min_year (index 0) or
//   max_year (index 1); only to be written while the pipeline is empty
// timing
//   ten register stages, 0 to 9: a result shows on out_valid once it reaches
//   stage 9, and it leaves on the edge at which out_stall is low; one
//   transaction per cycle sustained while out_stall is low
//   the three constant divisions (by 100, 12053 and 1461) are reciprocal
//   multiplies, each followed by a register and then its remainder stage
// reset
//   rst_n clears every stage valid bit and loads min_year 1970, max_year 2030
// backpressure
//   valid out_data holds while out_stall is high; bubbles in the pipeline still
//   fill, and in_stall rises only once every stage holds a live transaction
module gregorian_to_jalali_core
    import g2j_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  g2j_in_t     in_data,
    output logic        out_valid,
    input  logic        out_stall,
    output g2j_out_t    out_data,
    input  logic        cfg_wr_en,
    input  logic        cfg_index,
    input  logic [13:0] cfg_data
);

    logic [13:0] min_year_reg;
    logic [13:0] max_year_reg;

    logic [NUM_STAGES-1:0] ld;
    g2j_days_t             days;
    g2j_yday_t             yday;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_year_reg <= MIN_YEAR_RST;
            max_year_reg <= MAX_YEAR_RST;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_index)
                CFG_MIN_YEAR: min_year_reg <= cfg_data;
                CFG_MAX_YEAR: max_year_reg <= cfg_data;
            endcase
        end
    end

    // stage valid bits and load enables
    g2j_pipe_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .ld        (ld)
    );

    // stages 0 to 3: checks and day count
    g2j_day_count u_days (
        .clk      (clk),
        .ld       (ld[3:0]),
        .in_data  (in_data),
        .min_year (min_year_reg),
        .max_year (max_year_reg),
        .days     (days)
    );

    // stages 4 to 8: year cycles
    g2j_cycle_split u_split (
        .clk  (clk),
        .ld   (ld[8:4]),
        .days (days),
        .yday (yday)
    );

    // stage 9: month table and result register
    g2j_month_walk u_month (
        .clk      (clk),
        .ld       (ld[9]),
        .yday     (yday),
        .out_data (out_data)
    );

endmodule

// ===== hdl/g2j_checker.sv =====
// port-level checks of the converter, bound to the top level
module g2j_checker
    import g2j_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        in_stall,
    input logic        out_valid,
    input logic        out_stall,
    input g2j_out_t    out_data
);

    // a free output side must never push back on the input
    a_no_stall_when_free: assert property (@(posedge clk) disable iff (!rst_n)
        !out_stall |-> !in_stall)
        else $error("input stalled while output side is free");

    // a stalled result stays put
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(out_data))
        else $error("stalled result changed or vanished");

    // rejected dates carry all-zero fields
    a_invalid_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_data.valid_res |->
            out_data.jal_year == 14'd0 && out_data.jal_month == 4'd0
            && out_data.jal_day == 5'd0)
        else $error("invalid result with nonzero fields");

    // converted dates stay within the calendar
    a_valid_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.valid_res |->
            out_data.jal_month >= 4'd1 && out_data.jal_month <= 4'd12
            && out_data.jal_day >= 5'd1 && out_data.jal_day <= 5'd31
            && (out_data.jal_month <= 4'd6 || out_data.jal_day <= 5'd30))
        else $error("converted date out of range");

endmodule

bind gregorian_to_jalali_core g2j_checker u_g2j_checker (.*);

// ===== test/g2j_date_board_pkg.sv =====
// scoreboard class that predicts and checks gregorian to jalali conversions
`timescale 1ns / 1ps

package g2j_date_board_pkg;
    import g2j_pkg::*;

    localparam int GREG_MONTH_DAYS [12] = '{31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};
    localparam int JAL_MONTH_DAYS [12]  = '{31, 31, 31, 31, 31, 31, 30, 30, 30, 30, 30, 29};

    class g2j_date_board;
        logic [13:0] year_lo;
        logic [13:0] year_hi;
        g2j_out_t    pending_dates[$];
        int          mismatches;
        int          converted;
        int          valid_dates;

        function new();
            year_lo     = MIN_YEAR_RST;
            year_hi     = MAX_YEAR_RST;
            mismatches  = 0;
            converted   = 0;
            valid_dates = 0;
        endfunction

        function void set_reg(input logic idx, input logic [13:0] value);
            if (idx == CFG_MIN_YEAR)
                year_lo = value;
            else
                year_hi = value;
        endfunction

        function g2j_out_t convert_date(input g2j_in_t d);
            g2j_out_t    r;
            longint      gy;
            longint      days;
            longint      jy;
            int unsigned m;
            r = '0;
            if (d.greg_year < year_lo || d.greg_year > year_hi || d.greg_year < EPOCH_YEAR)
                return r;
            if (d.greg_month < 1 || d.greg_month > 12 || d.greg_day < 1 || d.greg_day > 31)
                return r;
            gy   = longint'(d.greg_year) - 1600;
            days = 365 * gy + (gy + 3) / 4 - (gy + 99) / 100 + (gy + 399) / 400;
            for (m = 0; m + 1 < d.greg_month; m++)
                days += GREG_MONTH_DAYS[m];
            // leap day counts once february is past
            if (d.greg_month > 2 && ((gy % 4 == 0 && gy % 100 != 0) || gy % 400 == 0))
                days++;
            days += longint'(d.greg_day) - 1;
            // before the first jalali new year of the count
            if (days < 79)
                return r;
            days -= 79;
            jy   = 979 + 33 * (days / 12053);
            days = days % 12053;
            jy  += 4 * (days / 1461);
            days = days % 1461;
            if (days >= 366)
            begin
                jy  += (days - 1) / 365;
                days = (days - 1) % 365;
            end
            // month walk never goes past the twelfth month
            m = 0;
            while (m < 11 && days >= JAL_MONTH_DAYS[m])
            begin
                days -= JAL_MONTH_DAYS[m];
                m++;
            end
            r.valid_res = 1'b1;
            r.jal_year  = 14'(jy);
            r.jal_month = 4'(m + 1);
            r.jal_day   = 5'(days + 1);
            return r;
        endfunction

        function void note_input(input g2j_in_t d);
            pending_dates.push_back(convert_date(d));
        endfunction

        function void check_result(input g2j_out_t got);
            g2j_out_t want;
            if (pending_dates.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result: valid=%0d year=%0d month=%0d day=%0d",
                             got.valid_res, got.jal_year, got.jal_month, got.jal_day);
                return;
            end
            want = pending_dates.pop_front();
            converted++;
            if (want.valid_res)
                valid_dates++;
            if (got.valid_res !== want.valid_res || got.jal_year !== want.jal_year ||
                got.jal_month !== want.jal_month || got.jal_day !== want.jal_day)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("mismatch: expected valid=%0d year=%0d month=%0d day=%0d, got valid=%0d year=%0d month=%0d day=%0d",
                             want.valid_res, want.jal_year, want.jal_month, want.jal_day,
                             got.valid_res, got.jal_year, got.jal_month, got.jal_day);
            end
        endfunction

        function int final_failures();
            if (pending_dates.size() != 0)
            begin
                $display("%0d results never arrived", pending_dates.size());
                mismatches += pending_dates.size();
            end
            return mismatches;
        endfunction
    endclass

endpackage

// ===== test/tb_top.sv =====
// top level testbench for the gregorian to jalali converter
`timescale 1ns / 1ps

module tb_top;
    import g2j_pkg::*;
    import g2j_date_board_pkg::*;

    // generous ceiling for the 515 transactions of the run plus drains
    localparam int CYCLE_LIMIT = 200000;
    localparam int PHASE_ITEMS = 70;

    logic     clk       = 1'b0;
    logic     rst_n     = 1'b0;
    logic     in_valid  = 1'b0;
    logic     in_stall;
    g2j_in_t  in_data   = '0;
    logic     out_valid;
    logic     out_stall = 1'b0;
    g2j_out_t out_data;
    logic        cfg_wr_en = 1'b0;
    logic        cfg_index = CFG_MIN_YEAR;
    logic [13:0] cfg_data  = '0;

    g2j_date_board board;
    int gap_pct     = 0;
    int stall_pct   = 0;
    int stall_left  = 0;
    int cycle_count = 0;
    int settings    = 0;
    bit quiet       = 1'b0;

    always #2 clk = ~clk;

    gregorian_to_jalali_core i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // receiver backpressure: random bursts of stalled cycles on out_stall
    always @(posedge clk)
    begin
        if (stall_left != 0)
        begin
            stall_left <= stall_left - 1;
            out_stall  <= 1'b1;
        end
        else if (!quiet && $urandom_range(0, 99) < stall_pct)
        begin
            out_stall  <= 1'b1;
            stall_left <= $urandom_range(0, 15);
        end
        else
            out_stall <= 1'b0;
    end

    // result monitor; values read here are the ones from before the edge
    always @(posedge clk)
    begin
        if (rst_n && board != null && out_valid && !out_stall)
            board.check_result(out_data);
    end

    // watchdog
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycle_count);
            $display("[gregorian_to_jalali_core] ERROR");
            $finish;
        end
    end

    // one input transaction, with an optional idle burst ahead of it;
    // the expectation is logged at the very edge that accepts it
    task automatic send_date(input g2j_in_t d);
        if (!quiet && gap_pct > 0 && $urandom_range(0, 99) < gap_pct)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 16)) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= d;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        board.note_input(d);
    endtask

    task automatic send_ymd(input int y, input int m, input int d);
        g2j_in_t item;
        item.greg_year  = 16'(y);
        item.greg_month = 8'(m);
        item.greg_day   = 8'(d);
        send_date(item);
    endtask

    // sender holds off until every outstanding result has come back
    task automatic drain();
        in_valid <= 1'b0;
        while (board.pending_dates.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // both bounds, written back to back while the pipeline is empty
    task automatic set_bounds(input int lo, input int hi);
        cfg_wr_en <= 1'b1;
        cfg_index <= CFG_MIN_YEAR;
        cfg_data  <= 14'(lo);
        @(posedge clk);
        board.set_reg(CFG_MIN_YEAR, 14'(lo));
        cfg_index <= CFG_MAX_YEAR;
        cfg_data  <= 14'(hi);
        @(posedge clk);
        board.set_reg(CFG_MAX_YEAR, 14'(hi));
        cfg_wr_en <= 1'b0;
        settings++;
    endtask

    // mostly well formed dates around the configured span, some noise
    function automatic g2j_in_t pick_date(input int lo, input int hi);
        g2j_in_t d;
        int      a;
        int      b;
        a = (lo < hi) ? lo : hi;
        b = (lo < hi) ? hi : lo;
        d.greg_year  = 16'($urandom_range(a, b));
        d.greg_month = 8'($urandom_range(1, 12));
        d.greg_day   = 8'($urandom_range(1, 31));
        case ($urandom_range(0, 19))
            0: d = g2j_in_t'($urandom);
            1: d.greg_year = 16'($urandom);
            2: d.greg_month = 8'($urandom);
            3: d.greg_day = 8'($urandom);
            // straddle either bound
            4: d.greg_year = 16'($urandom_range(0, 1) ? a + $urandom_range(0, 2) - 1
                                                     : b + $urandom_range(0, 2) - 1);
            // start of the count, around the first new year
            5:
            begin
                d.greg_year  = 16'd1600;
                d.greg_month = 8'($urandom_range(1, 4));
            end
            // around nowruz
            6:
            begin
                d.greg_month = 8'd3;
                d.greg_day   = 8'($urandom_range(17, 23));
            end
            // month ends, including days that spill over
            7: d.greg_day = 8'($urandom_range(28, 31));
            default: ;
        endcase
        return d;
    endfunction

    task automatic run_phase(input int lo, input int hi, input int gap, input int stall);
        drain();
        set_bounds(lo, hi);
        gap_pct   = gap;
        stall_pct = stall;
        repeat (PHASE_ITEMS)
            send_date(pick_date(lo, hi));
    endtask

    initial
    begin
        int lo;
        int hi;
        board = new();
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        settings = 1;

        // directed, reset bounds 1970..2030
        gap_pct   = 0;
        stall_pct = 10;
        send_ymd(1969, 6, 15);
        send_ymd(1970, 1, 1);
        send_ymd(2030, 12, 31);
        send_ymd(2031, 1, 1);
        send_ymd(2000, 0, 10);
        send_ymd(2000, 13, 10);
        send_ymd(2000, 255, 10);
        send_ymd(2000, 5, 0);
        send_ymd(2000, 5, 32);
        send_ymd(2000, 5, 255);
        send_ymd(0, 0, 0);
        send_ymd(65535, 255, 255);
        send_ymd(2001, 2, 31);      // spills into march
        send_ymd(2000, 2, 29);
        send_ymd(2024, 3, 20);
        send_ymd(2024, 3, 19);
        send_ymd(2025, 3, 20);      // thirtieth day of the last month

        // widest bounds: start of the count and the far end
        drain();
        set_bounds(1600, 9999);
        send_ymd(1600, 1, 1);
        send_ymd(1600, 3, 19);      // one day short of the first new year
        send_ymd(1600, 3, 20);
        send_ymd(1599, 12, 31);
        send_ymd(9999, 12, 31);
        send_ymd(1700, 3, 1);

        // crossed bounds accept nothing
        drain();
        set_bounds(2001, 2000);
        send_ymd(2000, 6, 6);
        send_ymd(2001, 6, 6);

        // random phases over several register settings
        run_phase(1600, 9999, 30, 20);
        run_phase(1970, 2030, 0, 0);
        lo = $urandom_range(1600, 9999);
        hi = $urandom_range(lo, 9999);
        run_phase(lo, hi, 15, 40);
        lo = $urandom_range(1600, 9999);
        run_phase(lo, lo, 40, 10);
        hi = $urandom_range(1600, 9998);
        lo = $urandom_range(hi + 1, 9999);
        run_phase(lo, hi, 20, 20);
        lo = $urandom_range(1600, 3000);
        hi = $urandom_range(8000, 9999);
        run_phase(lo, hi, 10, 50);

        // closing stretch, back to back on both sides
        drain();
        quiet = 1'b1;
        run_phase(1600, 9999, 0, 0);

        in_valid <= 1'b0;
        while (board.pending_dates.size() != 0)
            @(posedge clk);
        repeat (NUM_STAGES * 2) @(posedge clk);

        $display("covered %0d conversions, %0d of them valid, over %0d register settings",
                 board.converted, board.valid_dates, settings);
        $display("idle bursts of 1 to 16 cycles on both channels, final phase back to back");
        if (board.final_failures() == 0)
            $display("[gregorian_to_jalali_core] OK");
        else
            $display("[gregorian_to_jalali_core] ERROR");
        $finish;
    end

endmodule

// ===== sim.f =====
hdl/g2j_pkg.sv
hdl/g2j_pipe_ctrl.sv
hdl/g2j_day_count.sv
hdl/g2j_cycle_split.sv
hdl/g2j_month_walk.sv
hdl/gregorian_to_jalali_core.sv
hdl/g2j_checker.sv
test/g2j_date_board_pkg.sv
test/tb_top.sv
